FILE: hw/rtl/quat_to_euler_angles_assert.svh
// ----------------------------------------------------------------------------
// quaternion to euler angles: assertion macros
// clocked property checks, included by quat_to_euler_angles.sv, the one rtl file to assert
// ----------------------------------------------------------------------------
`ifndef QUAT_TO_EULER_ANGLES_ASSERT_SVH
`define QUAT_TO_EULER_ANGLES_ASSERT_SVH

// check on every rising edge, off while reset is applied
`define QTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// constants, arctangent table and angle helpers for the euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRACTION_BITS_DEF = 14;
	localparam int TABLE_LEN         = 24;

	// cordic datapath: x and y signed, z signed, 2^31 = pi
	localparam int CW      = 33;
	localparam int ZW      = 33;
	localparam int ANGLE_W = 34;

	// digit-by-digit square root: one result bit per step
	localparam int ISQ_STEPS = 31;
	localparam int ISQ_W     = 62;

	localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = ANGLE_W'(64'sd2147483648);
	localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = ANGLE_W'(64'sd1073741824);
	localparam logic signed [ANGLE_W-1:0] ROUND_HALF    = ANGLE_W'(64'sd32768);

	function automatic logic [31:0] atan_entry(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// round to 16-bit binary angle, wrapping
	function automatic logic [15:0] round_angle(input logic signed [ANGLE_W-1:0] a);
		logic signed [ANGLE_W-1:0] s;
		s = a + ROUND_HALF;
		return s[31:16];
	endfunction

	// four-quadrant angle from first-quadrant angle and the vector signs
	function automatic logic [15:0] restore_angle(input logic [30:0] t,
		input logic x_neg, input logic y_neg);
		logic signed [ANGLE_W-1:0] tt;
		logic signed [ANGLE_W-1:0] a;
		tt = {3'b000, t};
		if (!x_neg) begin
			a = y_neg ? -tt : tt;
		end else begin
			a = y_neg ? tt - ANGLE_PI : ANGLE_PI - tt;
		end
		return round_angle(a);
	endfunction

	// pitch: signed quarter turn when locked, else sign applied
	function automatic logic [15:0] pitch_of(input logic [30:0] t,
		input logic locked, input logic neg);
		logic signed [ANGLE_W-1:0] tt;
		logic signed [ANGLE_W-1:0] a;
		tt = locked ? ANGLE_QUARTER : {3'b000, t};
		a = neg ? -tt : tt;
		return round_angle(a);
	endfunction

endpackage

FILE: hw/rtl/quat_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quat_to_euler_angles
// unit quaternion to roll, pitch and yaw binary angles (z-y-x order)
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready with quat_w, quat_x, quat_y, quat_z in
//   signed fixed point (one = 2^FRACTION_BITS)
//   output channel: out_valid / out_ready with roll_angle, pitch_angle,
//   yaw_angle (32768 = pi) and pitch_clamped (gimbal lock)
//   one result per input transfer, in order
//   throughput: one transfer per cycle while the receiver keeps up
//   the pitch path runs through the 31-step square root chain followed by
//   the normalize and cordic cell chains, with NS = min(CORDIC_STAGES, 24)
//   cordic cells; roll and yaw wait in a delay line to stay aligned with it
//   the whole pipeline moves together; it advances whenever the output stage
//   is empty or being taken
//   while a result waits at the output with out_ready low, every stage holds
//   and in_ready is low in that same cycle, bubbles included
//   reset clears every stage valid bit; no reset of the datapath registers exists
// ----------------------------------------------------------------------------
module quat_to_euler_angles #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
	parameter int FRACTION_BITS = qte_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);
	import qte_pkg::*;

	// sum width covers one = 2^(2*FRACTION_BITS) plus doubled product sums
	localparam int SW  = (2 * FRACTION_BITS + 4 > 36) ? 2 * FRACTION_BITS + 4 : 36;
	localparam int MW  = SW - 1;
	localparam int NR  = $clog2(MW - 29);
	localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int LQ  = NR + 5 + NS + 1;
	localparam int DLY = 3 + ISQ_STEPS;
	localparam int LAT = 3 + 2 + ISQ_STEPS + LQ + 1;

	localparam logic signed [SW-1:0] ONE =
		{{(SW-1-2*FRACTION_BITS){1'b0}}, 1'b1, {(2*FRACTION_BITS){1'b0}}};
	localparam logic [ISQ_W-1:0] ONE60 = ISQ_W'(1) << 60;

	function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] n;
		n = -v;
		return v[SW-1] ? n[MW-1:0] : v[MW-1:0];
	endfunction

	// stage valid bits and common advance
	logic [LAT-1:0] vld_q;
	logic           en;

	assign en        = out_ready | ~vld_q[LAT-1];
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// s1: component products
	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wz_s1;
	logic signed [31:0] p_xy_s1, p_zz_s1, p_wy_s1, p_zx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
		end
	end

	// s2: sine and cosine terms, exact
	logic signed [SW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= (SW'(p_wx_s1) + SW'(p_yz_s1)) <<< 1;
			cr_s2 <= ONE - ((SW'(p_xx_s1) + SW'(p_yy_s1)) <<< 1);
			sy_s2 <= (SW'(p_wz_s1) + SW'(p_xy_s1)) <<< 1;
			cy_s2 <= ONE - ((SW'(p_yy_s1) + SW'(p_zz_s1)) <<< 1);
			sp_s2 <= (SW'(p_wy_s1) - SW'(p_zx_s1)) <<< 1;
		end
	end

	// s3: magnitudes and signs; pitch sine rescaled to 30 fraction bits
	logic [MW-1:0] roll_x_s3, roll_y_s3, yaw_x_s3, yaw_y_s3;
	logic [1:0]    roll_tag_s3, yaw_tag_s3;
	logic [29:0]   s30_s3;
	logic          lock_s3, pneg_s3;
	logic [MW-1:0] sp_mag;
	logic [29:0]   s30;

	assign sp_mag = mag_of(sp_s2);

	generate
		if (2 * FRACTION_BITS >= 30) begin : g_s30_down
			assign s30 = sp_mag[2*FRACTION_BITS-1 -: 30];
		end else begin : g_s30_up
			assign s30 = {sp_mag[2*FRACTION_BITS-1:0], {(30-2*FRACTION_BITS){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			roll_x_s3   <= mag_of(cr_s2);
			roll_y_s3   <= mag_of(sr_s2);
			roll_tag_s3 <= {cr_s2[SW-1], sr_s2[SW-1]};
			yaw_x_s3    <= mag_of(cy_s2);
			yaw_y_s3    <= mag_of(sy_s2);
			yaw_tag_s3  <= {cy_s2[SW-1], sy_s2[SW-1]};
			s30_s3      <= s30;
			lock_s3     <= |sp_mag[MW-1:2*FRACTION_BITS];
			pneg_s3     <= sp_s2[SW-1];
		end
	end

	// s4: square of the sine, s5: cosine squared
	logic [59:0]      sq_s4;
	logic [31:0]      ptag_s4, ptag_s5;
	logic [ISQ_W-1:0] rem_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= s30_s3 * s30_s3;
			ptag_s4 <= {s30_s3, lock_s3, pneg_s3};
			rem_s5  <= ONE60 - ISQ_W'(sq_s4);
			ptag_s5 <= ptag_s4;
		end
	end

	// square root chain for the pitch cosine
	logic [ISQ_W-1:0] irem  [ISQ_STEPS+1];
	logic [ISQ_W-1:0] iroot [ISQ_STEPS+1];
	logic [31:0]      itag  [ISQ_STEPS+1];

	assign irem[0]  = rem_s5;
	assign iroot[0] = '0;
	assign itag[0]  = ptag_s5;

	genvar g;
	generate
		for (g = 0; g < ISQ_STEPS; g++) begin : g_sqrt
			qte_isqrt_cell #(.J(ISQ_STEPS - 1 - g), .TW(32)) u_sqrt (
				.clk       (clk),
				.en        (en),
				.prev_rem  (irem[g]),
				.prev_root (iroot[g]),
				.prev_tag  (itag[g]),
				.next_rem  (irem[g+1]),
				.next_root (iroot[g+1]),
				.next_tag  (itag[g+1])
			);
		end
	endgenerate

	// three angle units
	logic [30:0] roll_t, yaw_t, pitch_t;
	logic [1:0]  roll_tag, yaw_tag, pitch_tag;

	qte_quadrant #(.MW(MW), .NR(NR), .NS(NS), .TW(2)) u_roll (
		.clk      (clk),
		.en       (en),
		.prev_x   (roll_x_s3),
		.prev_y   (roll_y_s3),
		.prev_tag (roll_tag_s3),
		.angle    (roll_t),
		.next_tag (roll_tag)
	);

	qte_quadrant #(.MW(MW), .NR(NR), .NS(NS), .TW(2)) u_yaw (
		.clk      (clk),
		.en       (en),
		.prev_x   (yaw_x_s3),
		.prev_y   (yaw_y_s3),
		.prev_tag (yaw_tag_s3),
		.angle    (yaw_t),
		.next_tag (yaw_tag)
	);

	qte_quadrant #(.MW(MW), .NR(NR), .NS(NS), .TW(2)) u_pitch (
		.clk      (clk),
		.en       (en),
		.prev_x   ({{(MW-31){1'b0}}, iroot[ISQ_STEPS][30:0]}),
		.prev_y   ({{(MW-30){1'b0}}, itag[ISQ_STEPS][31:2]}),
		.prev_tag (itag[ISQ_STEPS][1:0]),
		.angle    (pitch_t),
		.next_tag (pitch_tag)
	);

	// roll and yaw finish early and wait in a delay line for pitch
	logic [31:0] dly_q [DLY];
	logic [15:0] pitch_q;
	logic        lock_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= {restore_angle(roll_t, roll_tag[1], roll_tag[0]),
				restore_angle(yaw_t, yaw_tag[1], yaw_tag[0])};
			pitch_q  <= pitch_of(pitch_t, pitch_tag[1], pitch_tag[0]);
			lock_q   <= pitch_tag[1];
		end
	end

	generate
		for (g = 1; g < DLY; g++) begin : g_dly
			always_ff @(posedge clk) begin
				if (en) begin
					dly_q[g] <= dly_q[g-1];
				end
			end
		end
	endgenerate

	assign roll_angle    = dly_q[DLY-1][31:16];
	assign yaw_angle     = dly_q[DLY-1][15:0];
	assign pitch_angle   = pitch_q;
	assign pitch_clamped = lock_q;

	// checks
	`include "quat_to_euler_angles_assert.svh"

	`QTE_ASSERT(a_lock_quarter, out_valid && pitch_clamped |-> pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384, "locked pitch is not a quarter turn")
	`QTE_ASSERT(a_pitch_range, out_valid |-> pitch_angle >= -16'sd16384 && pitch_angle <= 16'sd16384, "pitch outside a quarter turn")
	`QTE_ASSERT_ALWAYS(a_stall_source, !in_ready |-> out_valid && !out_ready, "input held off without a stalled result")

endmodule

FILE: hw/rtl/qte_norm_cell.sv
// ----------------------------------------------------------------------------
// qte_norm_cell
// one conditional shift of a vector toward the range [2^29, 2^30)
// ----------------------------------------------------------------------------
module qte_norm_cell #(
	parameter int MW    = 35,
	parameter int SH    = 1,
	parameter bit RIGHT = 1'b1,
	parameter int TW    = 3
) (
	input  logic          clk,
	input  logic          en,
	input  logic [MW-1:0] prev_x,
	input  logic [MW-1:0] prev_y,
	input  logic [TW-1:0] prev_tag,
	output logic [MW-1:0] next_x,
	output logic [MW-1:0] next_y,
	output logic [TW-1:0] next_tag
);
	import qte_pkg::*;

	logic [MW-1:0] m;
	logic          do_shift;
	logic [MW-1:0] x_q, y_q;
	logic [TW-1:0] tag_q;

	assign m = (prev_x > prev_y) ? prev_x : prev_y;

	// right shift when m >= 2^(29+SH), so the cell leaves m below 2^(29+SH)
	generate
		if (RIGHT) begin : g_right
			if (29 + SH <= MW - 1) begin : g_cmp
				assign do_shift = |m[MW-1:29+SH];
			end else begin : g_none
				assign do_shift = 1'b0;
			end
		end else begin : g_left
			assign do_shift = ~|m[MW-1:30-SH];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= prev_tag;
			if (do_shift) begin
				x_q <= RIGHT ? (prev_x >> SH) : (prev_x << SH);
				y_q <= RIGHT ? (prev_y >> SH) : (prev_y << SH);
			end else begin
				x_q <= prev_x;
				y_q <= prev_y;
			end
		end
	end

	assign next_x   = x_q;
	assign next_y   = y_q;
	assign next_tag = tag_q;

endmodule

FILE: hw/rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring micro-rotation, driving y toward zero
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
	parameter int IDX = 0,
	parameter int TW  = 3
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [qte_pkg::CW-1:0]    prev_x,
	input  logic signed [qte_pkg::CW-1:0]    prev_y,
	input  logic signed [qte_pkg::ZW-1:0]    prev_z,
	input  logic        [TW-1:0]             prev_tag,
	output logic signed [qte_pkg::CW-1:0]    next_x,
	output logic signed [qte_pkg::CW-1:0]    next_y,
	output logic signed [qte_pkg::ZW-1:0]    next_z,
	output logic        [TW-1:0]             next_tag
);
	import qte_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = ZW'({1'b0, atan_entry(IDX)});

	logic signed [CW-1:0] dx, dy;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic        [TW-1:0] tag_q;

	// arithmetic shift is a floor shift
	assign dx = prev_y >>> IDX;
	assign dy = prev_x >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= prev_tag;
			if (!prev_y[CW-1]) begin
				x_q <= prev_x + dx;
				y_q <= prev_y - dy;
				z_q <= prev_z + ATAN;
			end else begin
				x_q <= prev_x - dx;
				y_q <= prev_y + dy;
				z_q <= prev_z - ATAN;
			end
		end
	end

	assign next_x   = x_q;
	assign next_y   = y_q;
	assign next_z   = z_q;
	assign next_tag = tag_q;

endmodule

FILE: hw/rtl/qte_isqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_isqrt_cell
// one step of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module qte_isqrt_cell #(
	parameter int J  = 0,
	parameter int TW = 32
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [qte_pkg::ISQ_W-1:0]   prev_rem,
	input  logic [qte_pkg::ISQ_W-1:0]   prev_root,
	input  logic [TW-1:0]               prev_tag,
	output logic [qte_pkg::ISQ_W-1:0]   next_rem,
	output logic [qte_pkg::ISQ_W-1:0]   next_root,
	output logic [TW-1:0]               next_tag
);
	import qte_pkg::*;

	localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * J);

	logic [ISQ_W-1:0] trial;
	logic [ISQ_W-1:0] rem_q, root_q;
	logic [TW-1:0]    tag_q;

	assign trial = prev_root + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= prev_tag;
			if (prev_rem >= trial) begin
				rem_q  <= prev_rem - trial;
				root_q <= (prev_root >> 1) + BIT;
			end else begin
				rem_q  <= prev_rem;
				root_q <= prev_root >> 1;
			end
		end
	end

	assign next_rem  = rem_q;
	assign next_root = root_q;
	assign next_tag  = tag_q;

endmodule

FILE: hw/rtl/qte_quadrant.sv
// ----------------------------------------------------------------------------
// qte_quadrant
// first-quadrant angle of a magnitude vector: normalize, rotate, clamp
// ----------------------------------------------------------------------------
module qte_quadrant #(
	parameter int MW = 35,
	parameter int NR = 3,
	parameter int NS = 16,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [MW-1:0] prev_x,
	input  logic [MW-1:0] prev_y,
	input  logic [TW-1:0] prev_tag,
	output logic [30:0]   angle,
	output logic [TW-1:0] next_tag
);
	import qte_pkg::*;

	localparam int NN = NR + 5;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);

	logic [MW-1:0] nx [NN+1];
	logic [MW-1:0] ny [NN+1];
	logic [TW:0]   nt [NN+1];

	logic signed [CW-1:0] cx [NS+1];
	logic signed [CW-1:0] cy [NS+1];
	logic signed [ZW-1:0] cz [NS+1];
	logic        [TW:0]   ct [NS+1];

	logic [30:0]   angle_q;
	logic [TW-1:0] tag_q;
	logic          zero_v;
	logic signed [ZW-1:0] zf;

	// zero vector flag rides with the tag
	assign nx[0] = prev_x;
	assign ny[0] = prev_y;
	assign nt[0] = {(prev_x == '0) && (prev_y == '0), prev_tag};

	genvar g;
	generate
		for (g = 0; g < NN; g++) begin : g_norm
			localparam bit RIGHT = (g < NR);
			localparam int SH = (g < NR) ? (1 << (NR - 1 - g)) : (1 << (4 - (g - NR)));
			qte_norm_cell #(.MW(MW), .SH(SH), .RIGHT(RIGHT), .TW(TW + 1)) u_norm (
				.clk      (clk),
				.en       (en),
				.prev_x   (nx[g]),
				.prev_y   (ny[g]),
				.prev_tag (nt[g]),
				.next_x   (nx[g+1]),
				.next_y   (ny[g+1]),
				.next_tag (nt[g+1])
			);
		end
	endgenerate

	assign cx[0] = {{(CW-30){1'b0}}, nx[NN][29:0]};
	assign cy[0] = {{(CW-30){1'b0}}, ny[NN][29:0]};
	assign cz[0] = '0;
	assign ct[0] = nt[NN];

	generate
		for (g = 0; g < NS; g++) begin : g_rot
			qte_cordic_cell #(.IDX(g), .TW(TW + 1)) u_rot (
				.clk      (clk),
				.en       (en),
				.prev_x   (cx[g]),
				.prev_y   (cy[g]),
				.prev_z   (cz[g]),
				.prev_tag (ct[g]),
				.next_x   (cx[g+1]),
				.next_y   (cy[g+1]),
				.next_z   (cz[g+1]),
				.next_tag (ct[g+1])
			);
		end
	endgenerate

	assign zero_v = ct[NS][TW];
	assign zf     = cz[NS];

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= ct[NS][TW-1:0];
			if (zero_v || zf[ZW-1]) begin
				angle_q <= '0;
			end else if (zf > QUARTER) begin
				angle_q <= QUARTER[30:0];
			end else begin
				angle_q <= zf[30:0];
			end
		end
	end

	assign angle    = angle_q;
	assign next_tag = tag_q;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for quat_to_euler_angles
// sends quaternions over the valid/ready input, predicts roll, pitch, yaw and
// the gimbal lock flag in 64-bit integer arithmetic, and checks each result
// transfer in order; covers corner orientations, random unit and raw
// quaternions, near-lock cases, a long receiver stall and a full drain pause
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int STAGES       = 16;
	localparam int FRAC         = 14;
	localparam longint ONE_Q    = 64'sd1 << (2 * FRAC);
	localparam longint TURN_HALF    = 64'sd1 << 31;
	localparam longint TURN_QUARTER = 64'sd1 << 30;
	localparam int UNIT         = 16384;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} euler_t;

	// arctangent of 2^-i, 2^31 = pi
	localparam logic [31:0] ATAN_LUT [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_clamped;

	euler_t expected_angles[$];
	int     err_count;
	int     sent_count;
	int     checked_count;
	int     lock_count;
	int     cycle_count;
	bit     idle_on;        // random gaps on both sides
	bit     long_hold_req;  // asks the receiver for one long stall
	int     hold_cnt;

	quat_to_euler_angles dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.roll_angle   (roll_angle),
		.pitch_angle  (pitch_angle),
		.yaw_angle    (yaw_angle),
		.pitch_clamped(pitch_clamped)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------ predictor

	// vectoring cordic on a first-quadrant vector, result in [0, quarter turn]
	function automatic longint quadrant_angle(longint unsigned ax, longint unsigned ay);
		longint unsigned m;
		longint cx, cy, ang, dx, dy;
		if (ax == 0 && ay == 0) begin
			return 0;
		end
		m = (ax > ay) ? ax : ay;
		// common shift so the larger magnitude lands in [2^29, 2^30)
		while (m >= (64'd1 << 30)) begin
			ax = ax >> 1;
			ay = ay >> 1;
			m  = m >> 1;
		end
		while (m < (64'd1 << 29)) begin
			ax = ax << 1;
			ay = ay << 1;
			m  = m << 1;
		end
		cx  = longint'(ax);
		cy  = longint'(ay);
		ang = 0;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx  = cx + dx;
				cy  = cy - dy;
				ang = ang + longint'(ATAN_LUT[i]);
			end else begin
				cx  = cx - dx;
				cy  = cy + dy;
				ang = ang - longint'(ATAN_LUT[i]);
			end
		end
		if (ang < 0) ang = 0;
		if (ang > TURN_QUARTER) ang = TURN_QUARTER;
		return ang;
	endfunction

	// four-quadrant arctangent, zero vector gives 0, negative x axis gives pi
	function automatic longint full_angle(longint sy, longint sx);
		longint unsigned ax, ay;
		longint t;
		ax = (sx < 0) ? longint'(-sx) : sx;
		ay = (sy < 0) ? longint'(-sy) : sy;
		t  = quadrant_angle(ax, ay);
		if (sx >= 0) begin
			return (sy >= 0) ? t : -t;
		end
		return (sy >= 0) ? TURN_HALF - t : t - TURN_HALF;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] binary_angle(longint a);
		longint unsigned s;
		s = longint'(a + 32768);
		return s[31:16];
	endfunction

	function automatic euler_t predict_euler(logic signed [15:0] qw, logic signed [15:0] qx,
		logic signed [15:0] qy, logic signed [15:0] qz);
		longint w, x, y, z, sr, cr, sy, cy, sp, pitch;
		longint unsigned mag, s30, c30;
		euler_t e;
		w  = qw;
		x  = qx;
		y  = qy;
		z  = qz;
		sr = 2 * (w * x + y * z);
		cr = ONE_Q - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = ONE_Q - 2 * (y * y + z * z);
		sp = 2 * (w * y - z * x);
		mag = (sp < 0) ? longint'(-sp) : sp;
		e.clamped = 1'b0;
		if (mag >= ONE_Q) begin
			// gimbal lock: signed quarter turn
			pitch     = (sp < 0) ? -TURN_QUARTER : TURN_QUARTER;
			e.clamped = 1'b1;
		end else begin
			s30   = mag << (30 - 2 * FRAC);
			c30   = int_sqrt((64'd1 << 60) - s30 * s30);
			pitch = quadrant_angle(c30, s30);
			if (sp < 0) pitch = -pitch;
		end
		e.roll  = binary_angle(full_angle(sr, cr));
		e.pitch = binary_angle(pitch);
		e.yaw   = binary_angle(full_angle(sy, cy));
		return e;
	endfunction

	// ------------------------------------------------------------------ sender

	// one input transfer; called and returning at a rising edge
	task automatic send_quat(int w, int x, int y, int z);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		quat_w   <= 16'(w);
		quat_x   <= 16'(x);
		quat_y   <= 16'(y);
		quat_z   <= 16'(z);
		do @(posedge clk); while (!in_ready);
		expected_angles.push_back(predict_euler(16'(w), 16'(x), 16'(y), 16'(z)));
		sent_count++;
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int clip_unit(int v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	function automatic int to_fixed(real v);
		return clip_unit($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
	endfunction

	// random unit quaternion, roughly uniform directions
	task automatic send_unit_quat();
		real a, b, c, d, n;
		do begin
			a = ($itor($urandom_range(0, 65536)) - 32768.0) / 32768.0;
			b = ($itor($urandom_range(0, 65536)) - 32768.0) / 32768.0;
			c = ($itor($urandom_range(0, 65536)) - 32768.0) / 32768.0;
			d = ($itor($urandom_range(0, 65536)) - 32768.0) / 32768.0;
			n = $sqrt(a * a + b * b + c * c + d * d);
		end while (n < 0.05);
		send_quat(to_fixed(a / n), to_fixed(b / n), to_fixed(c / n), to_fixed(d / n));
	endtask

	// near gimbal lock: w and y close to +-1/sqrt2 with small x and z
	task automatic send_near_lock();
		int c, sgn;
		c   = 11585 + $urandom_range(0, 8) - 4;
		sgn = $urandom_range(0, 1) ? 1 : -1;
		send_quat(c, $urandom_range(0, 40) - 20, sgn * c, $urandom_range(0, 40) - 20);
	endtask

	task automatic send_raw_quat();
		send_quat($urandom_range(0, 2 * UNIT) - UNIT, $urandom_range(0, 2 * UNIT) - UNIT,
			$urandom_range(0, 2 * UNIT) - UNIT, $urandom_range(0, 2 * UNIT) - UNIT);
	endtask

	task automatic send_mixed();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) send_unit_quat();
		else if (pick < 8) send_near_lock();
		else send_raw_quat();
	endtask

	task automatic wait_drained();
		while (expected_angles.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------ receiver

	// random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold_req && hold_cnt == 0) begin
			long_hold_req <= 1'b0;
			hold_cnt      <= 200;
			out_ready     <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= (hold_cnt == 1);
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_cnt  <= $urandom_range(1, 19);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------ checker

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("mismatch on result %0d: %s expected %0d got %0d",
			checked_count, what, exp_v, got_v);
		err_count++;
	endtask

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected transfer, queue depth", 0, 1);
			end else begin
				e = expected_angles.pop_front();
				if (roll_angle !== e.roll) report_mismatch("roll", e.roll, roll_angle);
				if (pitch_angle !== e.pitch) report_mismatch("pitch", e.pitch, pitch_angle);
				if (yaw_angle !== e.yaw) report_mismatch("yaw", e.yaw, yaw_angle);
				if (pitch_clamped !== e.clamped)
					report_mismatch("pitch_clamped", e.clamped, pitch_clamped);
				if (e.clamped) lock_count++;
			end
			checked_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------ tests

	// identity, axes, half turns, extremes, zero vector and gimbal lock
	task automatic test_directed();
		send_quat(UNIT, 0, 0, 0);
		send_quat(-UNIT, 0, 0, 0);
		send_quat(0, UNIT, 0, 0);            // roll of pi
		send_quat(0, 0, UNIT, 0);
		send_quat(0, 0, 0, UNIT);            // yaw of pi
		send_quat(0, -UNIT, 0, 0);
		send_quat(0, 0, -UNIT, 0);
		send_quat(0, 0, 0, -UNIT);
		send_quat(0, 0, 0, 0);               // all-zero input
		send_quat(UNIT, UNIT, UNIT, UNIT);
		send_quat(-UNIT, -UNIT, -UNIT, -UNIT);
		send_quat(UNIT, -UNIT, UNIT, -UNIT);
		send_quat(11585, 0, 11585, 0);       // near lock, positive
		send_quat(11585, 0, -11585, 0);      // near lock, negative
		send_quat(8192, 8192, 8192, -8192);  // lock through the zx term
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, 0, 0, 11585);
		send_quat(11585, 0, 0, -11585);
		send_quat(11584, 0, 11584, 0);       // just short of lock
		send_quat(16383, 1, -1, 16383);
		send_quat(1, 0, 0, 0);
		send_quat(-1, -1, -1, -1);
		send_quat(0, 8192, 0, 0);            // non-unit, roll from a short vector
		send_quat(-16384, 16383, -16383, 1);
	endtask

	task automatic test_random_mix(int n);
		repeat (n) send_mixed();
	endtask

	// receiver holds off while the sender keeps offering, filling the pipeline
	task automatic test_long_stall();
		idle_on = 1'b0;
		long_hold_req <= 1'b1;
		repeat (150) send_mixed();
		idle_on = 1'b1;
	endtask

	// sender waits for every outstanding result before going on
	task automatic test_drain_pause();
		repeat (40) send_mixed();
		pause_sender();
		wait_drained();
		repeat (40) send_mixed();
	endtask

	task automatic test_full_rate(int n);
		idle_on = 1'b0;
		repeat (n) send_mixed();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		quat_w        = '0;
		quat_x        = '0;
		quat_y        = '0;
		quat_z        = '0;
		out_ready     = 1'b0;
		err_count     = 0;
		sent_count    = 0;
		checked_count = 0;
		lock_count    = 0;
		cycle_count   = 0;
		idle_on       = 1'b1;
		long_hold_req = 1'b0;
		hold_cnt      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(450);
		test_long_stall();
		test_drain_pause();
		test_full_rate(180);

		pause_sender();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d quaternions, checked %0d angle sets, %0d in gimbal lock",
			sent_count, checked_count, lock_count);
		$display("covered corner orientations, random unit and raw inputs, long stall");
		if (err_count == 0 && expected_angles.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_norm_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/qte_isqrt_cell.sv
hw/rtl/qte_quadrant.sv
hw/rtl/quat_to_euler_angles.sv
tb/sv/testbench.sv
